FILE: hw/rtl/adts_pkg.sv
// Shared types, constants and header byte formatting for the ADTS header framer.
`default_nettype none

package adts_pkg;

  // Fixed header layout and limits.
  localparam int unsigned HdrLen = 7;
  localparam logic [7:0] SyncHi = 8'hFF;
  localparam logic [7:0] SyncLo = 8'hF1;
  localparam logic [13:0] MaxPayloadLen = 14'd8184;
  localparam logic [2:0] PayloadPos = 3'(HdrLen);
  localparam logic [2:0] LastHdrPos = 3'(HdrLen - 1);

  // Positions of the header bytes.
  localparam logic [2:0] PosSyncHi = 3'd0;
  localparam logic [2:0] PosSyncLo = 3'd1;
  localparam logic [2:0] PosCfg = 3'd2;
  localparam logic [2:0] PosChLen = 3'd3;
  localparam logic [2:0] PosLenMid = 3'd4;
  localparam logic [2:0] PosLenLo = 3'd5;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_PROFILE = 2'd0,
    CFG_RATE    = 2'd1,
    CFG_CHANNEL = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [13:0] packet_length;
    logic        last_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_header;
    logic       frame_end;
    logic       length_error;
  } out_req_t;

  typedef struct packed {
    logic [1:0] index;
    logic [3:0] data;
  } cfg_req_t;

  typedef struct packed {
    logic [1:0] profile_code;
    logic [3:0] rate_index;
    logic [2:0] channel_config;
  } cfg_t;

  // One accepted request with its frame context resolved.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        last_byte;
    logic        start;
    logic        empty;
    logic        err;
    logic [12:0] total;
  } item_t;

  // Header byte at a given position; position six is zero buffer fullness.
  // The configuration byte keeps a zero private bit between the sampling index
  // and the top channel bit.
  function automatic logic [7:0] hdr_byte(logic [2:0] pos, cfg_t c, logic [12:0] total);
    logic [7:0] b;
    b = 8'h00;
    unique case (pos)
      PosSyncHi: b = SyncHi;
      PosSyncLo: b = SyncLo;
      PosCfg:    b = {c.profile_code, c.rate_index, 1'b0, c.channel_config[2]};
      PosChLen:  b = {c.channel_config[1:0], 4'b0000, total[12:11]};
      PosLenMid: b = total[10:3];
      PosLenLo:  b = {total[2:0], 5'b00000};
      default:   b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/adts_stream_if.sv
// Valid/ready channel interface carrying one payload struct.
`default_nettype none

interface adts_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/adts_header_framer_top.sv
// Top level of the ADTS header framer.
// Usage:
//   in_i  : one request per payload byte (payload_byte, packet_length, last_byte).
//           packet_length is read on the first request of each packet.
//   out_o : framed byte stream; each request carries out_byte, is_header,
//           frame_end and length_error.
//   cfg_i : register writes (index 0 profile, 1 sampling index, 2 channel code),
//           always ready; write only while the framer is idle.
// Timing: an accepted request sits in the input register, and the emitter moves
// each byte into the output register on out_o. Payload streams at one byte per
// cycle while out_o is not stalled. The first request of a packet holds the input
// register while the emitter walks seven header bytes and the payload byte, or
// the seven header bytes alone for a zero length packet.
// Reset: registers return to profile 1, sampling index 4, channel code 2, the
// framer expects a new packet, and no output is valid.
// Stall: while out_o.ready is low the output register holds its byte, the
// emitter waits, and in_i.ready drops once the input register is occupied.
`default_nettype none

module adts_header_framer_top (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  adts_stream_if.sink   in_i,
  adts_stream_if.source out_o,
  adts_stream_if.sink   cfg_i
);

  adts_pkg::cfg_t  cfg;
  adts_pkg::item_t item;
  logic            item_vld;
  logic            take;

  adts_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  adts_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .take_i     (take),
    .item_vld_o (item_vld),
    .item_o     (item)
  );

  adts_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_vld_i (item_vld),
    .item_i     (item),
    .cfg_i      (cfg),
    .take_o     (take),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/adts_cfg_regs.sv
// Configuration registers for profile, sampling index and channel code.
`default_nettype none

module adts_cfg_regs (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  adts_stream_if.sink cfg_i,
  output adts_pkg::cfg_t cfg_o
);

  adts_pkg::cfg_t cfg_q, cfg_d;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        adts_pkg::CFG_PROFILE: cfg_d.profile_code = cfg_i.payload.data[1:0];
        adts_pkg::CFG_RATE:    cfg_d.rate_index = cfg_i.payload.data[3:0];
        adts_pkg::CFG_CHANNEL: cfg_d.channel_config = cfg_i.payload.data[2:0];
        default:               cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.profile_code <= 2'd1;
      cfg_q.rate_index <= 4'd4;
      cfg_q.channel_config <= 3'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: hw/rtl/adts_in_stage.sv
// Input register: captures a request and resolves its frame start and error flags.
`default_nettype none

module adts_in_stage (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  adts_stream_if.sink in_i,
  input  wire logic   take_i,
  output logic        item_vld_o,
  output adts_pkg::item_t item_o
);

  logic            vld_q, vld_d;
  logic            start_q, start_d;
  logic            err_q, err_d;
  adts_pkg::item_t item_q, item_d;
  logic            accept;

  // The slot frees in the same cycle the emitter finishes the held request.
  assign in_i.ready = !vld_q || take_i;
  assign accept = in_i.valid && in_i.ready;

  // Frame context for the incoming request.
  always_comb begin
    item_d.payload_byte = in_i.payload.payload_byte;
    item_d.last_byte = in_i.payload.last_byte;
    item_d.start = start_q;
    item_d.empty = start_q && (in_i.payload.packet_length == 14'd0);
    item_d.err = start_q ? (in_i.payload.packet_length > adts_pkg::MaxPayloadLen) : err_q;
    item_d.total = in_i.payload.packet_length[12:0] + 13'(adts_pkg::HdrLen);
  end

  // A frame closes on an empty packet or on the last payload byte.
  always_comb begin
    vld_d = take_i ? 1'b0 : vld_q;
    start_d = start_q;
    err_d = err_q;
    if (accept) begin
      vld_d = 1'b1;
      if (item_d.empty || in_i.payload.last_byte) begin
        start_d = 1'b1;
        err_d = 1'b0;
      end else begin
        start_d = 1'b0;
        err_d = item_d.err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      start_q <= 1'b1;
      err_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      start_q <= start_d;
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_vld_o = vld_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

FILE: hw/rtl/adts_emit.sv
// Byte emitter: walks the header and payload of the held request into the output register.
`default_nettype none

module adts_emit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            item_vld_i,
  input  wire adts_pkg::item_t item_i,
  input  wire adts_pkg::cfg_t  cfg_i,
  output logic                 take_o,
  adts_stream_if.source        out_o
);

  logic               out_vld_q, out_vld_d;
  adts_pkg::out_req_t out_q, out_d;
  logic [2:0]         cnt_q, cnt_d;
  logic [2:0]         pos;
  logic               load, fire, final_b;

  assign load = !out_vld_q || out_o.ready;
  assign fire = item_vld_i && load;

  // Position inside the framed packet; continuation bytes sit at the payload slot.
  assign pos = item_i.start ? cnt_q : adts_pkg::PayloadPos;

  always_comb begin
    if (!item_i.start) begin
      final_b = 1'b1;
    end else if (item_i.empty) begin
      final_b = (cnt_q == adts_pkg::LastHdrPos);
    end else begin
      final_b = (cnt_q == adts_pkg::PayloadPos);
    end
  end

  assign take_o = fire && final_b;

  // Next output byte and its flags.
  always_comb begin
    out_d.is_header = (pos != adts_pkg::PayloadPos);
    out_d.out_byte = out_d.is_header ? adts_pkg::hdr_byte(pos, cfg_i, item_i.total)
                                     : item_i.payload_byte;
    out_d.frame_end = out_d.is_header ? (item_i.empty && pos == adts_pkg::LastHdrPos)
                                      : item_i.last_byte;
    out_d.length_error = item_i.err;
  end

  // Counter and output register control.
  always_comb begin
    cnt_d = cnt_q;
    out_vld_d = out_vld_q;
    if (load) begin
      out_vld_d = item_vld_i;
    end
    if (fire) begin
      cnt_d = final_b ? 3'd0 : cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      cnt_q <= 3'd0;
    end else begin
      out_vld_q <= out_vld_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.payload = out_q;

`ifndef SYNTHESIS
  // The byte counter only runs while a request is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 3'd0 |-> item_vld_i)
    else $error("byte counter advanced without a held request");

  // Continuation bytes never start mid-count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_i && !item_i.start |-> cnt_q == 3'd0)
    else $error("continuation request with nonzero byte count");

  // A header-only frame never reaches the payload slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_vld_i && item_i.empty |-> cnt_q != adts_pkg::PayloadPos)
    else $error("empty packet reached the payload slot");

  // A frame that ends inside the header ends on the zero fullness byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.is_header && out_q.frame_end |-> out_q.out_byte == 8'h00)
    else $error("header-only frame ended on a nonzero byte");
`endif

endmodule

`default_nettype wire

FILE: verif/adts_header_framer_top_tb.sv
// Self-checking testbench for the ADTS header framer: predicted framed bytes versus DUT output.
module adts_header_framer_top_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned MaxWait = 8;
  localparam int unsigned ResetCycles = 9;
  localparam logic [1:0] CfgSpare = 2'd3;

  logic clk_i;
  logic rst_ni;

  adts_stream_if #(.payload_t(adts_pkg::in_req_t)) in_if ();
  adts_stream_if #(.payload_t(adts_pkg::out_req_t)) out_if ();
  adts_stream_if #(.payload_t(adts_pkg::cfg_req_t)) cfg_if ();

  adts_header_framer_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Framer state as the testbench sees it, plus the framed bytes still owed by the DUT.
  adts_pkg::cfg_t     shadow_cfg;
  logic               at_start;
  logic               err_latch;
  adts_pkg::out_req_t framed_q[$];
  int unsigned        mismatch_count;
  int unsigned        cycle_count;
  bit                 steady;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Wait drawn for one request; zero during steady stretches.
  function automatic int unsigned draw_wait();
    if (steady) begin
      return 0;
    end
    return $urandom_range(0, MaxWait);
  endfunction

  function automatic void push_framed(logic [7:0] b, logic hdr, logic fend, logic err);
    adts_pkg::out_req_t r;
    r.out_byte = b;
    r.is_header = hdr;
    r.frame_end = fend;
    r.length_error = err;
    framed_q.push_back(r);
  endfunction

  // Expected framed bytes for one accepted input request.
  function automatic void frame_request(adts_pkg::in_req_t req);
    logic [14:0] sum;
    logic [12:0] flen;
    logic        empty;
    if (at_start) begin
      sum = {1'b0, req.packet_length} + 15'(adts_pkg::HdrLen);
      flen = sum[12:0];
      empty = (req.packet_length == 14'd0);
      err_latch = (req.packet_length > adts_pkg::MaxPayloadLen);
      push_framed(adts_pkg::SyncHi, 1'b1, 1'b0, err_latch);
      push_framed(adts_pkg::SyncLo, 1'b1, 1'b0, err_latch);
      push_framed({shadow_cfg.profile_code, shadow_cfg.rate_index, 1'b0,
                   shadow_cfg.channel_config[2]}, 1'b1, 1'b0, err_latch);
      push_framed({shadow_cfg.channel_config[1:0], 4'b0000, flen[12:11]},
                  1'b1, 1'b0, err_latch);
      push_framed(flen[10:3], 1'b1, 1'b0, err_latch);
      push_framed({flen[2:0], 5'b00000}, 1'b1, 1'b0, err_latch);
      // Buffer fullness is zero; a header-only frame ends here.
      push_framed(8'h00, 1'b1, empty, err_latch);
      if (empty) begin
        err_latch = 1'b0;
        return;
      end
      at_start = 1'b0;
    end
    push_framed(req.payload_byte, 1'b0, req.last_byte, err_latch);
    if (req.last_byte) begin
      at_start = 1'b1;
      err_latch = 1'b0;
    end
  endfunction

  // Register write as the framer applies it; only the low bits of each field survive.
  function automatic void apply_write(adts_pkg::cfg_req_t w);
    case (w.index)
      adts_pkg::CFG_PROFILE: shadow_cfg.profile_code = w.data[1:0];
      adts_pkg::CFG_RATE:    shadow_cfg.rate_index = w.data[3:0];
      adts_pkg::CFG_CHANNEL: shadow_cfg.channel_config = w.data[2:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Send one payload request; entered and left just after a falling edge.
  task automatic send_request(logic [7:0] pbyte, logic [13:0] plen, logic last);
    adts_pkg::in_req_t req;
    int unsigned       gap;
    req.payload_byte = pbyte;
    req.packet_length = plen;
    req.last_byte = last;
    gap = draw_wait();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.payload <= req;
    do @(posedge clk_i); while (!in_if.ready);
    frame_request(req);
    @(negedge clk_i);
  endtask

  // One packet: the first request announces the length, later ones carry noise there.
  task automatic send_packet(logic [13:0] announced, int unsigned count);
    if (announced == 14'd0) begin
      send_request(8'($urandom_range(0, 255)), 14'd0, 1'($urandom_range(0, 1)));
      return;
    end
    for (int unsigned i = 0; i < count; i++) begin
      send_request(8'($urandom_range(0, 255)),
                   (i == 0) ? announced : 14'($urandom_range(0, 16383)),
                   (i == count - 1));
    end
  endtask

  // Stop sending and wait until every framed byte has come out.
  task automatic settle_idle();
    in_if.valid <= 1'b0;
    while (framed_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_one(logic [1:0] idx, logic [3:0] data);
    adts_pkg::cfg_req_t w;
    w.index = idx;
    w.data = data;
    cfg_if.valid <= 1'b1;
    cfg_if.payload <= w;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_write(w);
    @(negedge clk_i);
  endtask

  // Write all three registers, optionally followed by a write to the unused index.
  task automatic write_config(logic [3:0] prof, logic [3:0] rate, logic [3:0] chan,
                              bit spare);
    write_one(adts_pkg::CFG_PROFILE, prof);
    write_one(adts_pkg::CFG_RATE, rate);
    write_one(adts_pkg::CFG_CHANNEL, chan);
    if (spare) begin
      write_one(CfgSpare, 4'($urandom_range(0, 15)));
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Single-byte, header-only, multi-byte and mismatched packets at reset settings.
  task automatic test_edge_packets();
    send_request(8'hFF, 14'd1, 1'b1);
    send_request(8'h00, 14'd0, 1'b1);
    send_request(8'hA5, 14'd0, 1'b0);
    send_request(8'h00, 14'd3, 1'b0);
    send_request(8'h5A, 14'h3FFF, 1'b0);
    send_request(8'hC3, 14'h0000, 1'b1);
    // Packet ends before the announced length.
    send_request(8'h12, 14'd6, 1'b0);
    send_request(8'h34, 14'd6, 1'b1);
    // Packet runs past the announced length.
    send_request(8'h81, 14'd1, 1'b0);
    send_request(8'h7E, 14'd1, 1'b0);
    send_request(8'h0F, 14'd1, 1'b1);
  endtask

  // Frame length field around the largest legal payload and beyond.
  task automatic test_length_limits();
    send_request(8'h11, 14'd8184, 1'b1);
    send_request(8'h22, 14'd8185, 1'b1);
    send_request(8'h33, 14'd8191, 1'b1);
    send_request(8'h44, 14'h3FFF, 1'b0);
    send_request(8'h55, 14'h2AAA, 1'b1);
    send_request(8'h66, 14'h2AAA, 1'b1);
    send_request(8'h77, 14'h1555, 1'b1);
  endtask

  // Register extremes, write truncation and the unused index.
  task automatic test_register_extremes();
    settle_idle();
    write_config(4'd0, 4'd0, 4'd0, 1'b1);
    send_packet(14'd2, 2);
    send_packet(14'd0, 1);
    settle_idle();
    write_config(4'd3, 4'd15, 4'd7, 1'b0);
    send_packet(14'd1, 1);
    send_packet(14'd8190, 2);
    settle_idle();
    write_config(4'hE, 4'hA, 4'hD, 1'b1);
    send_packet(14'd3, 3);
    settle_idle();
    write_config(4'hF, 4'h5, 4'hA, 1'b0);
    send_packet(14'd1, 1);
  endtask

  // Random packets in phases, each under a fresh random configuration.
  task automatic test_random_stream();
    int unsigned sent;
    int unsigned pick;
    int unsigned count;
    logic [13:0] announced;
    for (int phase = 0; phase < 6; phase++) begin
      settle_idle();
      write_config(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      steady = (phase == 2) || (phase == 4);
      sent = 0;
      while (sent < 12) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          // Well-formed short packet.
          count = $urandom_range(1, 6);
          announced = 14'(count);
        end else if (pick < 72) begin
          count = $urandom_range(1, 8);
          announced = 14'($urandom_range(1, 8));
        end else if (pick < 80) begin
          count = 1;
          announced = 14'd0;
        end else if (pick < 88) begin
          count = $urandom_range(1, 4);
          announced = 14'($urandom_range(1, 16383));
        end else begin
          count = $urandom_range(7, 40);
          announced = 14'(count);
        end
        send_packet(announced, count);
        sent += count;
      end
    end
    steady = 1'b0;
  endtask

  // Output side: random stall before each framed byte is taken.
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = draw_wait();
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      @(negedge clk_i);
    end
  end

  // Compare each accepted framed byte with the oldest expectation.
  always @(posedge clk_i) begin
    adts_pkg::out_req_t want;
    adts_pkg::out_req_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (framed_q.size() == 0) begin
        $display("%0t: unexpected framed byte, expected none, actual %02h hdr %0b end %0b err %0b",
                 $time, got.out_byte, got.is_header, got.frame_end,
                 got.length_error);
        mismatch_count++;
      end else begin
        want = framed_q.pop_front();
        check_field("out_byte", want.out_byte, got.out_byte);
        check_field("is_header", 8'(want.is_header), 8'(got.is_header));
        check_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
        check_field("length_error", 8'(want.length_error), 8'(got.length_error));
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("adts_header_framer_top verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    steady = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    at_start = 1'b1;
    err_latch = 1'b0;
    shadow_cfg.profile_code = 2'd1;
    shadow_cfg.rate_index = 4'd4;
    shadow_cfg.channel_config = 3'd2;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_edge_packets();
    test_length_limits();
    test_register_extremes();
    test_random_stream();
    settle_idle();

    if (mismatch_count == 0) begin
      $display("adts_header_framer_top verification clean");
    end else begin
      $display("adts_header_framer_top verification failed");
    end
    $finish;
  end

endmodule
